// ===== rtl/f2i_pkg.sv =====
// ----------------------------------------------------------------------------
// f2i_pkg
// shared types and constants for the single-precision to integer converter
// ----------------------------------------------------------------------------
package f2i_pkg;

	typedef enum logic [1:0] {
		RM_NEAREST = 2'd0,
		RM_DOWN    = 2'd1,
		RM_UP      = 2'd2,
		RM_ZERO    = 2'd3
	} rmode_t;

	localparam logic [63:0] IND64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] IND32 = 64'h0000_0000_8000_0000;
	localparam logic [7:0]  EXP_SPECIAL = 8'hFF;

	typedef struct packed {
		logic        sign;
		logic        wide;
		logic        special;
		logic        big;
		logic [63:0] mag;
		logic        inc;
	} stage_t;

endpackage

// ===== rtl/float32_to_int_convert.sv =====
// ----------------------------------------------------------------------------
// float32_to_int_convert
// single-precision to signed 32/64-bit integer conversion
// ----------------------------------------------------------------------------
// One word is taken per cycle whenever start is high; busy is always low.
// The result reaches done through the input register, then alignment and
// rounding into the result register. Results cannot be held
// off, so every accepted word yields exactly one done pulse.
module float32_to_int_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic        wide,
	input  logic [31:0] float_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	output logic        done,
	output logic [63:0] int_result
);
	f2i_pkg::rmode_t mode_q;
	logic            v_s1, v_s2;
	logic            kind_s1, wide_s1;
	logic [31:0]     bits_s1;
	f2i_pkg::stage_t st;
	logic [63:0]     res_s2;
	logic [64:0]     m;
	logic [63:0]     res;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= f2i_pkg::RM_NEAREST;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_q <= f2i_pkg::rmode_t'(cfg_data);
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		wide_s1 <= wide;
		bits_s1 <= float_bits;
		res_s2  <= res;
	end

	f2i_align u_align (
		.kind       (kind_s1),
		.wide       (wide_s1),
		.float_bits (bits_s1),
		.mode_cfg   (mode_q),
		.st         (st)
	);

	always_comb begin
		m = {1'b0, st.mag} + {64'd0, st.inc};
		if (st.special || st.big)
			res = st.wide ? f2i_pkg::IND64 : f2i_pkg::IND32;
		else if (st.wide) begin
			if (m > (st.sign ? 65'h0_8000_0000_0000_0000 : 65'h0_7FFF_FFFF_FFFF_FFFF))
				res = f2i_pkg::IND64;
			else
				res = st.sign ? (64'd0 - m[63:0]) : m[63:0];
		end else begin
			if (m > (st.sign ? 65'h0_0000_0000_8000_0000 : 65'h0_0000_0000_7FFF_FFFF))
				res = f2i_pkg::IND32;
			else
				res = {32'd0, st.sign ? (32'd0 - m[31:0]) : m[31:0]};
		end
	end

	assign done       = v_s2;
	assign int_result = res_s2;

	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done) else $error("lost word");
	a_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !wide_s1) |=> (int_result[63:32] == 32'd0)) else $error("narrow high");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && bits_s1[30:23] == 8'hFF && wide_s1) |=> int_result == f2i_pkg::IND64)
		else $error("special");
endmodule

// ===== rtl/f2i_align.sv =====
// ----------------------------------------------------------------------------
// f2i_align
// aligns the significand and decides the rounding increment
// ----------------------------------------------------------------------------
module f2i_align (
	input  logic                 kind,
	input  logic                 wide,
	input  logic [31:0]          float_bits,
	input  f2i_pkg::rmode_t      mode_cfg,
	output f2i_pkg::stage_t      st
);
	logic        sign;
	logic [7:0]  expo;
	logic [23:0] sig;
	logic [8:0]  e;
	logic [87:0] ext;
	logic [63:0] mag;
	logic        guard;
	logic        sticky;
	logic        inexact;
	logic        inc;
	f2i_pkg::rmode_t mode;

	always_comb begin
		sign  = float_bits[31];
		expo  = float_bits[30:23];
		sig   = (expo == 8'd0) ? {1'b0, float_bits[22:0]} : {1'b1, float_bits[22:0]};
		e     = (expo == 8'd0) ? 9'd1 : {1'b0, expo};
		mode  = kind ? mode_cfg : f2i_pkg::RM_ZERO;
		// fixed point: value = ext[87:24] . ext[23:0], binary point at 24
		ext   = 88'd0;
		if (e >= 9'd126 && e <= 9'd190)
			ext = {64'd0, sig} << (e - 9'd126);
		mag     = ext[87:24];
		guard   = ext[23];
		sticky  = (e < 9'd126) ? (sig != 24'd0) : (ext[22:0] != 23'd0);
		if (e < 9'd126)
			guard = 1'b0;
		inexact = guard | sticky;
		if (e < 9'd126)
			inexact = sig != 24'd0;
		unique case (mode)
			f2i_pkg::RM_NEAREST: inc = guard & (sticky | mag[0]);
			f2i_pkg::RM_DOWN:    inc = inexact & sign;
			f2i_pkg::RM_UP:      inc = inexact & ~sign;
			default:             inc = 1'b0;
		endcase
		st.sign    = sign;
		st.wide    = wide;
		st.special = (expo == f2i_pkg::EXP_SPECIAL);
		st.big     = (e > 9'd190);
		st.mag     = mag;
		st.inc     = inc;
	end
endmodule
